FILE: sv/dlrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlrs_pkg: shared definitions for the bounded OSA row engine
// Sizes, codes and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package dlrs_pkg;

  // Storage sizes.
  localparam int MAX_WORD   = 32;
  localparam int MAX_DEPTH  = 64;
  localparam int ROW_LEN    = MAX_WORD + 1;
  localparam int CELL_DEPTH = (MAX_DEPTH + 1) * ROW_LEN;
  localparam int CELL_AW    = $clog2(CELL_DEPTH);
  localparam int ROW_AW     = $clog2(MAX_DEPTH + 1);
  localparam int QAW        = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
  localparam int COL_W      = $clog2(ROW_LEN + 1);
  localparam int BND_W      = (COL_W + 2 > 8) ? COL_W + 2 : 8;

  // Field widths.
  localparam int CELL_W = 7;
  localparam int SYM_W  = 8;
  localparam int DEP_W  = 7;
  localparam int POS_W  = 5;
  localparam int WL_W   = 6;
  localparam int MD_W   = 5;
  localparam int CIDX_W = 2;

  localparam logic [CELL_W-1:0] CELL_MAX = '1;
  localparam logic signed [CELL_W-1:0] GOOD_NONE = -7'sd1;

  // Request opcodes.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] REG_WORD_LENGTH = 2'd0;
  localparam logic [CIDX_W-1:0] REG_DIST_LIMIT  = 2'd1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;         // write one query character
    logic accept_step;  // latch a step request
    logic meta;         // read parent metadata, write column zero
    logic prime;        // capture parent column zero, start column reads
    logic col;          // compute one column
    logic finish;       // store row metadata, present the result
  } dlrs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_load;
    logic step_ok;
    logic last_col;
    logic no_cols;
  } dlrs_status_t;

endpackage

FILE: sv/damerau_levenshtein_row_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// damerau_levenshtein_row_step: bounded restricted edit-distance row engine
// Builds one trie-walk table row per step request against a loaded query word.
// ----------------------------------------------------------------------------
// A load request (opcode 0) writes one query character in the cycle it is
// accepted and leaves busy low. A step request (opcode 1) with a valid depth
// reads the parent row's metadata, primes the row memory reads, then computes
// columns 1 to word_length, with word_length capped at 32, one at a time, since
// each cell depends on its left neighbor, and ends in one result state. The
// next request can be accepted in the cycle after the result.
// A step with a bad depth is dropped with no result. The result is shown for
// exactly one cycle with done high and must be taken then; the receiver cannot
// stall it. The row memory needs no clearing pass after reset. Configuration
// writes are always taken (cfg_ready is high) and should be made only while
// the block is idle.
// ----------------------------------------------------------------------------
module damerau_levenshtein_row_step (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              opcode,
  input  logic [dlrs_pkg::POS_W-1:0]        position,
  input  logic [dlrs_pkg::SYM_W-1:0]        symbol,
  input  logic [dlrs_pkg::DEP_W-1:0]        depth,
  output logic                              done,
  output logic [dlrs_pkg::CELL_W-1:0]       distance,
  output logic                              prune,
  output logic signed [dlrs_pkg::CELL_W-1:0] last_good_column,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dlrs_pkg::CIDX_W-1:0]       cfg_index,
  input  logic [dlrs_pkg::WL_W-1:0]         cfg_data
);
  import dlrs_pkg::*;

  dlrs_cmd_t    cmd;
  dlrs_status_t status;

  assign cfg_ready = 1'b1;

  // Sequencer.
  dlrs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // Storage and cell arithmetic.
  dlrs_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .opcode           (opcode),
    .position         (position),
    .symbol           (symbol),
    .depth            (depth),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .distance         (distance),
    .prune            (prune),
    .last_good_column (last_good_column)
  );

endmodule

FILE: sv/dlrs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlrs_ctrl: sequencer for the row engine
// Accepts requests and steps the datapath through metadata, columns and result.
// ----------------------------------------------------------------------------
module dlrs_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  dlrs_pkg::dlrs_status_t status,
  output dlrs_pkg::dlrs_cmd_t    cmd,
  output logic                  busy,
  output logic                  done
);
  import dlrs_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_META  = 3'd1;
  localparam logic [2:0] S_PRIME = 3'd2;
  localparam logic [2:0] S_COL   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start && !status.is_load && status.step_ok) state_next = S_META;
      end
      S_META:  state_next = S_PRIME;
      S_PRIME: state_next = status.no_cols ? S_DONE : S_COL;
      S_COL: begin
        if (status.last_col) state_next = S_DONE;
      end
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Commands follow the state directly.
  always_comb begin
    cmd.load        = (state == S_IDLE) && start && status.is_load;
    cmd.accept_step = (state == S_IDLE) && start && !status.is_load && status.step_ok;
    cmd.meta        = (state == S_META);
    cmd.prime       = (state == S_PRIME);
    cmd.col         = (state == S_COL);
    cmd.finish      = (state == S_DONE);
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule

FILE: sv/dlrs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlrs_datapath: row storage and the serial cell update
// Holds the query word, stored rows and config, and computes one cell a cycle.
// ----------------------------------------------------------------------------
module dlrs_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  dlrs_pkg::dlrs_cmd_t               cmd,
  output dlrs_pkg::dlrs_status_t            status,
  input  logic                              opcode,
  input  logic [dlrs_pkg::POS_W-1:0]        position,
  input  logic [dlrs_pkg::SYM_W-1:0]        symbol,
  input  logic [dlrs_pkg::DEP_W-1:0]        depth,
  input  logic                              cfg_valid,
  input  logic [dlrs_pkg::CIDX_W-1:0]       cfg_index,
  input  logic [dlrs_pkg::WL_W-1:0]         cfg_data,
  output logic [dlrs_pkg::CELL_W-1:0]       distance,
  output logic                              prune,
  output logic signed [dlrs_pkg::CELL_W-1:0] last_good_column
);
  import dlrs_pkg::*;

  // Saturating increment of a cell value.
  function automatic logic [CELL_W-1:0] inc_sat(input logic [CELL_W-1:0] x);
    return (x == CELL_MAX) ? x : x + 1'b1;
  endfunction

  function automatic logic [CELL_W-1:0] min_cell(input logic [CELL_W-1:0] a,
                                                 input logic [CELL_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  // Storage; contents are undefined until written.
  logic [SYM_W-1:0]  query_mem [MAX_WORD];
  logic [CELL_W-1:0] cell_mem  [CELL_DEPTH];
  logic [CELL_W-1:0] good_mem  [MAX_DEPTH + 1];
  logic [SYM_W-1:0]  sym_mem   [MAX_DEPTH + 1];

  // Configuration registers.
  logic [WL_W-1:0] word_length;
  logic [MD_W-1:0] dist_limit;

  // Per-step registers.
  logic [SYM_W-1:0]  sym_c;
  logic [DEP_W-1:0]  depth_r;
  logic [COL_W-1:0]  wl;
  logic [CELL_AW-1:0] pbase;
  logic [CELL_AW-1:0] gbase;
  logic [CELL_AW-1:0] cbase;
  logic [ROW_AW-1:0] cur_row;
  logic              root_parent;
  logic              root_grand;
  logic              has_grand;
  logic [COL_W-1:0]  col;
  logic [CELL_W-1:0] pjm1;
  logic [SYM_W-1:0]  qprev;
  logic [CELL_W-1:0] last_val;
  logic signed [CELL_W-1:0] good;

  // Registered read data.
  logic [SYM_W-1:0]  q_rd;
  logic [CELL_W-1:0] pcell_rd;
  logic [CELL_W-1:0] gcell_rd;
  logic [CELL_W-1:0] good_rd;
  logic [SYM_W-1:0]  sym_rd;

  // Combinational signals.
  logic [COL_W-1:0]   wl_clamp;
  logic [CELL_AW-1:0] depth_ext;
  logic [COL_W-1:0]   rcol;
  logic [COL_W-1:0]   qcol;
  logic [COL_W-1:0]   gcol;
  logic [CELL_AW-1:0] pcell_addr;
  logic [CELL_AW-1:0] gcell_addr;
  logic [CELL_AW-1:0] wcell_addr;
  logic [CELL_W-1:0]  wcell_data;
  logic               wcell_en;
  logic [CELL_W-1:0]  pj;
  logic [CELL_W-1:0]  gj;
  logic signed [CELL_W-1:0] pgood;
  logic signed [BND_W-1:0]  bound_lim;
  logic signed [BND_W-1:0]  col_s;
  logic               in_bound;
  logic               miss;
  logic               trans;
  logic [CELL_W-1:0]  best;
  logic [CELL_W-1:0]  v;
  logic               v_good;
  logic [CELL_W-1:0]  md_ext;

  assign md_ext = CELL_W'(dist_limit);

  // Configuration writes are always taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      word_length <= '0;
      dist_limit  <= MD_W'(2);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WORD_LENGTH: word_length <= cfg_data;
        REG_DIST_LIMIT:  dist_limit  <= cfg_data[MD_W-1:0];
        default: ;
      endcase
    end
  end

  // Status toward the controller.
  always_comb begin
    status.is_load  = (opcode == OP_LOAD);
    status.step_ok  = (depth != '0) && (int'(depth) <= MAX_DEPTH);
    status.last_col = (col == wl);
    status.no_cols  = (wl == '0);
  end

  // Query length is capped at the stored word size.
  always_comb begin
    if (int'(word_length) > MAX_WORD) wl_clamp = COL_W'(MAX_WORD);
    else wl_clamp = COL_W'(word_length);
  end

  assign depth_ext = CELL_AW'(depth);

  // Latch a step request and derive the row base addresses.
  always_ff @(posedge clk) begin
    if (cmd.accept_step) begin
      sym_c       <= symbol;
      depth_r     <= depth;
      wl          <= wl_clamp;
      cur_row     <= ROW_AW'(depth);
      cbase       <= depth_ext * CELL_AW'(ROW_LEN);
      pbase       <= (depth_ext - 1'b1) * CELL_AW'(ROW_LEN);
      gbase       <= (depth > DEP_W'(1)) ? (depth_ext - CELL_AW'(2)) * CELL_AW'(ROW_LEN)
                                         : '0;
      root_parent <= (depth == DEP_W'(1));
      root_grand  <= (depth == DEP_W'(2));
      has_grand   <= (depth > DEP_W'(1));
    end
  end

  // Reads run one column ahead of the computation.
  always_comb begin
    if (cmd.meta) rcol = '0;
    else if (cmd.prime) rcol = COL_W'(1);
    else rcol = col + 1'b1;
    qcol = (rcol != '0) ? rcol - 1'b1 : '0;
    gcol = (rcol > COL_W'(1)) ? rcol - COL_W'(2) : '0;
    pcell_addr = pbase + CELL_AW'(rcol);
    gcell_addr = gbase + CELL_AW'(gcol);
  end

  // Query character store.
  always_ff @(posedge clk) begin
    if (cmd.load && (int'(position) < MAX_WORD)) begin
      query_mem[QAW'(position)] <= symbol;
    end
    q_rd <= query_mem[qcol[QAW-1:0]];
  end

  // Row metadata store: read at the parent, written at the end of the step.
  always_ff @(posedge clk) begin
    if (cmd.meta) begin
      good_rd <= good_mem[cur_row - 1'b1];
      sym_rd  <= sym_mem[cur_row - 1'b1];
    end
    if (cmd.finish) begin
      good_mem[cur_row] <= good;
      sym_mem[cur_row]  <= sym_c;
    end
  end

  // Row cell store: one write port, parent and grandparent read ports.
  always_comb begin
    wcell_en   = cmd.meta || cmd.col;
    wcell_addr = cbase + (cmd.meta ? '0 : CELL_AW'(col));
    wcell_data = cmd.meta ? CELL_W'(depth_r) : v;
  end

  always_ff @(posedge clk) begin
    if (wcell_en) begin
      cell_mem[wcell_addr] <= wcell_data;
    end
    pcell_rd <= cell_mem[pcell_addr];
    gcell_rd <= cell_mem[gcell_addr];
  end

  // Neighbor cells; the root row holds its own column index.
  always_comb begin
    pj    = root_parent ? CELL_W'(col) : pcell_rd;
    gj    = root_grand ? CELL_W'(col - COL_W'(2)) : gcell_rd;
    pgood = root_parent ? signed'(md_ext) : signed'(good_rd);
  end

  // Cell update: insert, delete, substitute and adjacent transposition.
  always_comb begin
    bound_lim = BND_W'(pgood) + BND_W'(2);
    col_s     = signed'(BND_W'(col));
    in_bound  = (col_s < bound_lim);
    miss      = (sym_c != q_rd);
    trans     = has_grand && (col > COL_W'(1)) && (sym_c == qprev) && (sym_rd == q_rd);
    best      = min_cell(inc_sat(pj), inc_sat(last_val));
    best      = min_cell(best, miss ? inc_sat(pjm1) : pjm1);
    if (trans) best = min_cell(best, miss ? inc_sat(gj) : gj);
    v      = in_bound ? best : md_ext + 1'b1;
    v_good = in_bound && (best <= md_ext);
  end

  // Column sweep registers.
  always_ff @(posedge clk) begin
    if (cmd.meta) begin
      last_val <= CELL_W'(depth_r);
      good     <= (CELL_W'(depth_r) <= md_ext) ? '0 : GOOD_NONE;
    end
    if (cmd.prime) begin
      col  <= COL_W'(1);
      pjm1 <= root_parent ? '0 : pcell_rd;
    end
    if (cmd.col) begin
      col      <= col + 1'b1;
      pjm1     <= pj;
      qprev    <= q_rd;
      last_val <= v;
      if (v_good) good <= signed'(CELL_W'(col));
    end
  end

  // Result fields stay on the sweep registers.
  assign distance         = last_val;
  assign prune            = good[CELL_W-1];
  assign last_good_column = good;

endmodule

FILE: sim/dlrs_row_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlrs_row_checker: result checker for the bounded OSA row engine
// Watches the request, configuration and result channels, keeps its own copy
// of the query word and the stored rows, predicts each row result and
// compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module dlrs_row_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic                               busy,
  input  logic                               opcode,
  input  logic [dlrs_pkg::POS_W-1:0]         position,
  input  logic [dlrs_pkg::SYM_W-1:0]         symbol,
  input  logic [dlrs_pkg::DEP_W-1:0]         depth,
  input  logic                               done,
  input  logic [dlrs_pkg::CELL_W-1:0]        distance,
  input  logic                               prune,
  input  logic signed [dlrs_pkg::CELL_W-1:0] last_good_column,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [dlrs_pkg::CIDX_W-1:0]        cfg_index,
  input  logic [dlrs_pkg::WL_W-1:0]          cfg_data,
  output int                                 mismatches,
  output int                                 outstanding
);
  import dlrs_pkg::*;

  typedef struct packed {
    logic [CELL_W-1:0] distance;
    logic              prune;
    logic [CELL_W-1:0] good_col;
  } row_result_t;

  // Shadow copy of the configuration and the block's storage.
  logic [WL_W-1:0] word_len;
  logic [MD_W-1:0] dist_bound;
  int query_sym [MAX_WORD];
  int row_cell  [MAX_DEPTH+1][ROW_LEN];
  int row_good  [MAX_DEPTH+1];
  int row_sym   [MAX_DEPTH+1];

  row_result_t expected_rows[$];
  int err_cnt = 0;
  int result_no = 0;

  function automatic int clip(int v);
    return (v > int'(CELL_MAX)) ? int'(CELL_MAX) : v;
  endfunction

  function automatic int min_of(int a, int b);
    return (a < b) ? a : b;
  endfunction

  // The root row at depth zero is implicit: each cell is its column index.
  function automatic int cell_of(int d, int j);
    if (d == 0)
      return clip(j);
    return row_cell[d][j];
  endfunction

  // Builds the row for candidate c at depth d, stores it and returns the result.
  function automatic row_result_t compute_row(int c, int d);
    int width, parent, parent_good, bound, good, v, miss, qc, j;
    int cur [ROW_LEN];
    row_result_t r;
    width = ((word_len > MAX_WORD) ? MAX_WORD : int'(word_len)) + 1;
    parent = d - 1;
    parent_good = (parent == 0) ? int'(dist_bound) : row_good[parent];
    cur[0] = clip(d);
    good = (d <= dist_bound) ? 0 : -1;
    bound = parent_good + 2;
    if (bound < 1)
      bound = 1;
    if (bound > width)
      bound = width;

    // Serial column walk up to the bound; each cell needs its left neighbor.
    for (j = 1; j < bound; j++) begin
      qc = query_sym[j-1];
      miss = (c != qc) ? 1 : 0;
      v = min_of(clip(cell_of(parent, j) + 1), clip(cur[j-1] + 1));
      v = min_of(v, clip(cell_of(parent, j-1) + miss));
      // Adjacent transposition of the last two characters.
      if (d > 1 && j > 1 && c == query_sym[j-2] && row_sym[parent] == qc)
        v = min_of(v, clip(cell_of(d-2, j-2) + miss));
      cur[j] = v;
      if (v <= dist_bound)
        good = j;
    end
    // Columns past the bound are known to be out of reach.
    for (; j < width; j++)
      cur[j] = dist_bound + 1;

    for (j = 0; j < width; j++)
      row_cell[d][j] = cur[j];
    row_good[d] = good;
    row_sym[d] = c;

    r.distance = cur[width-1][CELL_W-1:0];
    r.prune = (good < 0);
    r.good_col = good[CELL_W-1:0];
    return r;
  endfunction

  task automatic note_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10)
      $display("ERROR: %s", msg);
  endtask

  always @(posedge clk) begin : watch
    row_result_t want;
    if (rst) begin
      word_len = '0;
      dist_bound = MD_W'(2);
      for (int i = 0; i < MAX_WORD; i++)
        query_sym[i] = 0;
      for (int d = 0; d <= MAX_DEPTH; d++) begin
        row_good[d] = 0;
        row_sym[d] = 0;
        for (int j = 0; j < ROW_LEN; j++)
          row_cell[d][j] = 0;
      end
      expected_rows.delete();
    end else begin
      // Results first: a result never belongs to a request taken this edge.
      if (done) begin
        result_no++;
        if (expected_rows.size() == 0) begin
          note_error($sformatf("result %0d arrived with none pending (distance %0d)",
                               result_no, distance));
        end else begin
          want = expected_rows.pop_front();
          if (distance !== want.distance || prune !== want.prune ||
              last_good_column !== want.good_col)
            note_error($sformatf(
              "result %0d distance %0d/%0d prune %0b/%0b last_good_column %0d/%0d",
              result_no, want.distance, distance, want.prune, prune,
              $signed(want.good_col), last_good_column));
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WORD_LENGTH: word_len = cfg_data[WL_W-1:0];
          REG_DIST_LIMIT:  dist_bound = cfg_data[MD_W-1:0];
          default: ;
        endcase
      end

      if (start && !busy) begin
        if (opcode == OP_LOAD) begin
          if (position < MAX_WORD)
            query_sym[position] = symbol;
        end else if (depth != 0 && depth <= MAX_DEPTH) begin
          expected_rows.insert(expected_rows.size(), compute_row(symbol, depth));
        end
      end
    end
    mismatches <= err_cnt;
    outstanding <= expected_rows.size();
  end

endmodule

FILE: sim/damerau_levenshtein_row_step_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// damerau_levenshtein_row_step_tb: testbench for the bounded OSA row engine
// Loads query words, walks trie paths depth first with mostly matching
// characters and random gaps, and lets the checker compare every row result.
// ----------------------------------------------------------------------------
module damerau_levenshtein_row_step_tb;
  import dlrs_pkg::*;

  localparam logic [CIDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CIDX_W-1:0] REG_SPARE_3 = 2'd3;
  localparam int TARGET_ITEMS = 1050;
  localparam int SETTLE_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic opcode = OP_LOAD;
  logic [POS_W-1:0] position = '0;
  logic [SYM_W-1:0] symbol = '0;
  logic [DEP_W-1:0] depth = '0;
  logic done;
  logic [CELL_W-1:0] distance;
  logic prune;
  logic signed [CELL_W-1:0] last_good_column;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CIDX_W-1:0] cfg_index = '0;
  logic [WL_W-1:0] cfg_data = '0;
  int mismatches;
  int outstanding;

  // Stimulus state: query word as loaded, deepest row valid for this width.
  logic [SYM_W-1:0] word_chars [MAX_WORD];
  logic [SYM_W-1:0] alpha_base;
  int walk_depth;
  int items = 0;
  bit steady;

  always #1 clk = ~clk;

  damerau_levenshtein_row_step dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .position(position), .symbol(symbol), .depth(depth), .done(done),
    .distance(distance), .prune(prune), .last_good_column(last_good_column),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  dlrs_row_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .position(position), .symbol(symbol), .depth(depth), .done(done),
    .distance(distance), .prune(prune), .last_good_column(last_good_column),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .mismatches(mismatches), .outstanding(outstanding)
  );

  // Mostly back to back or short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (steady)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Candidate characters mostly follow the query, sometimes swap or miss.
  function automatic logic [SYM_W-1:0] pick_symbol(int d);
    int r;
    r = $urandom_range(0, 9);
    if (r < 6 && d <= MAX_WORD)
      return word_chars[d-1];
    if (r < 8 && d < MAX_WORD)
      return word_chars[d];
    if (r < 9)
      return alpha_base ^ SYM_W'($urandom_range(0, 3));
    return SYM_W'($urandom_range(0, 255));
  endfunction

  // One request: held until accepted, then an optional gap.
  task automatic send_request(input logic op, input logic [POS_W-1:0] pos,
                              input logic [SYM_W-1:0] sym,
                              input logic [DEP_W-1:0] dep);
    int gap;
    start <= 1'b1;
    opcode <= op;
    position <= pos;
    symbol <= sym;
    depth <= dep;
    do @(posedge clk); while (busy);
    if (op == OP_LOAD || (dep != 0 && dep <= MAX_DEPTH))
      items++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic step_at(input int d, input logic [SYM_W-1:0] sym);
    send_request(OP_STEP, POS_W'($urandom), sym, DEP_W'(d));
    if (d > walk_depth)
      walk_depth = d;
  endtask

  task automatic bad_step(input int d);
    send_request(OP_STEP, POS_W'($urandom), SYM_W'($urandom), DEP_W'(d));
  endtask

  task automatic load_query(input int len);
    for (int p = 0; p < len && p < MAX_WORD; p++)
      send_request(OP_LOAD, POS_W'(p), word_chars[p], DEP_W'($urandom));
  endtask

  // Drop start and wait until every result is back and the block is quiet.
  task automatic quiesce();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0 || busy);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [WL_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Safety net against a hung handshake.
  initial begin
    #1_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    int wl, md, r, start_depth, span, d, branches;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: short word with extreme characters, matches, a transposition,
    // bad depths on both sides.
    write_reg(REG_WORD_LENGTH, WL_W'(4));
    write_reg(REG_DIST_LIMIT, WL_W'(2));
    word_chars[0] = 8'h00;
    word_chars[1] = 8'hFF;
    word_chars[2] = 8'h5A;
    word_chars[3] = 8'hA5;
    alpha_base = 8'h5A;
    walk_depth = 0;
    steady = 1'b0;
    load_query(4);
    step_at(1, 8'h00);
    step_at(2, 8'h5A);
    step_at(3, 8'hFF);
    step_at(4, 8'hA5);
    step_at(1, 8'hFF);
    step_at(2, 8'h00);
    bad_step(0);
    bad_step(MAX_DEPTH + 1);
    bad_step(127);

    // Directed: empty word and a zero bound, so every row is pruned.
    quiesce();
    write_reg(REG_WORD_LENGTH, WL_W'(0));
    write_reg(REG_DIST_LIMIT, WL_W'(0));
    walk_depth = 0;
    step_at(1, 8'h00);
    step_at(2, 8'hFF);
    step_at(3, 8'h81);

    // Random phases: new settings, a new word, then depth-first walks.
    while (items < TARGET_ITEMS) begin
      quiesce();
      r = $urandom_range(0, 9);
      if (r == 0)
        wl = 0;
      else if (r == 1)
        wl = MAX_WORD;
      else if (r == 2)
        wl = $urandom_range(MAX_WORD + 1, 63);
      else if (r < 7)
        wl = $urandom_range(1, 8);
      else
        wl = $urandom_range(9, MAX_WORD - 1);
      r = $urandom_range(0, 9);
      if (r == 0)
        md = 0;
      else if (r == 1)
        md = 31;
      else if (r < 8)
        md = $urandom_range(1, 4);
      else
        md = $urandom_range(0, 31);
      if ($urandom_range(0, 5) == 0)
        write_reg(($urandom_range(0, 1) == 0) ? REG_SPARE_2 : REG_SPARE_3,
                  WL_W'($urandom));
      write_reg(REG_WORD_LENGTH, WL_W'(wl));
      // The spare top data bit is set at random on the narrower register.
      write_reg(REG_DIST_LIMIT, {1'($urandom_range(0, 1)), MD_W'(md)});

      steady = ($urandom_range(0, 3) == 0);
      alpha_base = SYM_W'($urandom);
      for (int p = 0; p < MAX_WORD; p++)
        word_chars[p] = ($urandom_range(0, 7) == 0) ? SYM_W'($urandom)
                                                     : alpha_base ^ SYM_W'($urandom_range(0, 3));
      load_query(wl);
      walk_depth = 0;

      branches = $urandom_range(4, 10);
      repeat (branches) begin
        r = $urandom_range(0, 19);
        if (r == 0) begin
          // Noise: a depth the block must drop.
          bad_step(($urandom_range(0, 1) == 0) ? 0 : $urandom_range(MAX_DEPTH + 1, 127));
        end else if (r == 1) begin
          // Noise: rewrite one query character.
          d = $urandom_range(0, MAX_WORD - 1);
          word_chars[d] = SYM_W'($urandom);
          send_request(OP_LOAD, POS_W'(d), word_chars[d], DEP_W'($urandom));
        end else begin
          // A branch of the walk: consecutive depths from a valid parent.
          start_depth = $urandom_range(1, (walk_depth < MAX_DEPTH) ? walk_depth + 1
                                                                   : MAX_DEPTH);
          span = ($urandom_range(0, 9) == 0) ? MAX_DEPTH : $urandom_range(1, 6);
          for (d = start_depth; d <= MAX_DEPTH && d < start_depth + span; d++)
            step_at(d, pick_symbol(d));
        end
      end
    end

    quiesce();
    if (mismatches == 0 && outstanding == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

FILE: sim.f
sv/dlrs_pkg.sv
sv/dlrs_ctrl.sv
sv/dlrs_datapath.sv
sv/damerau_levenshtein_row_step.sv
sim/dlrs_row_checker.sv
sim/damerau_levenshtein_row_step_tb.sv
